@@ rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // byte classes found by the front end
   localparam logic [3:0] CLS_OTHER    = 4'd0;
   localparam logic [3:0] CLS_NL       = 4'd1;
   localparam logic [3:0] CLS_CR       = 4'd2;
   localparam logic [3:0] CLS_TAB      = 4'd3;
   localparam logic [3:0] CLS_ESC      = 4'd4;
   localparam logic [3:0] CLS_LBRACKET = 4'd5;
   localparam logic [3:0] CLS_DIGIT0   = 4'd6;
   localparam logic [3:0] CLS_DIGIT_NZ = 4'd7;
   localparam logic [3:0] CLS_M        = 4'd8;

   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_NL       = 8'h0a;
   localparam logic [7:0] CH_CR       = 8'h0d;
   localparam logic [7:0] CH_ESC      = 8'h1b;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_NINE     = 8'h39;
   localparam logic [7:0] CH_LBRACKET = 8'h5b;
   localparam logic [7:0] CH_M        = 8'h6d;

   // escape phases
   localparam logic [1:0] ESC_NONE = 2'd0;
   localparam logic [1:0] ESC_SEEN = 2'd1;
   localparam logic [1:0] ESC_CSI  = 2'd2;

   // configuration register indexes and reset values
   localparam logic REG_NORMAL_ATTR = 1'b0;
   localparam logic REG_BRIGHT_ATTR = 1'b1;
   localparam logic [7:0] NORMAL_ATTR_RESET = 8'h07;
   localparam logic [7:0] BRIGHT_ATTR_RESET = 8'h0f;

   typedef struct packed {
      logic       is_read;
      logic       in_range;
      logic [3:0] cls;
   } tcw_class_type;

   typedef struct packed {
      logic full;
      logic empty;
   } tcw_queue_status_type;

   typedef struct packed {
      logic init_busy;
      logic pop;
   } tcw_back_status_type;

endpackage

@@ rtl/text_console_writer_core.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine: bottom-row writer with scrolling and SGR attributes.
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall  op, char_byte, read_row, read_column
//   rsp      out  rsp_valid/rsp_stall  cell_char, cell_attr, cursor_column,
//                                      bright_active
//   csr      in   csr_write            csr_index, csr_data
//
// Plain writes and in-range cell reads go through the back end's execute or
// read state; an out-of-range read is answered from idle. A newline clears
// the new bottom row (rows form a ring in the screen RAM). The first write
// after reset and a printable byte at the wrap column also clear a row first.
// After reset, req_stall stays high while the screen RAM is cleared; the
// two-entry queue keeps taking items while results wait, until it is full.
// ----------------------------------------------------------------------------
module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [7:0]                   req_char_byte,
   input  logic [$clog2(ROWS)-1:0]      req_read_row,
   input  logic [$clog2(COLUMNS)-1:0]   req_read_column,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_cell_char,
   output logic [7:0]                   rsp_cell_attr,
   output logic [$clog2(COLUMNS+1)-1:0] rsp_cursor_column,
   output logic                         rsp_bright_active,
   input  logic                         csr_write,
   input  logic                         csr_index,
   input  logic [7:0]                   csr_data
);

   localparam int RW = $clog2(ROWS);
   localparam int XW = $clog2(COLUMNS);
   localparam int CW = $clog2(COLUMNS+1);
   localparam int AW = $clog2(ROWS*COLUMNS);
   localparam int CLW = $bits(tcw_class_type);
   localparam int QW = CLW + 8 + RW + XW;

   logic [7:0] normal_attr_ff, normal_attr_in;
   logic [7:0] bright_attr_ff, bright_attr_in;

   tcw_class_type        front_class;
   tcw_class_type        head_class;
   tcw_queue_status_type q_status;
   tcw_back_status_type  b_status;
   logic [QW-1:0]        push_data;
   logic [QW-1:0]        head_data;
   logic [7:0]           head_char;
   logic [RW-1:0]        head_row;
   logic [XW-1:0]        head_col;
   logic                 push;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [15:0]          ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [15:0]          ram_rd_data;

   always_comb begin
      normal_attr_in = normal_attr_ff;
      bright_attr_in = bright_attr_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_NORMAL_ATTR: normal_attr_in = csr_data;
            REG_BRIGHT_ATTR: bright_attr_in = csr_data;
            default:         normal_attr_in = normal_attr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_attr_ff <= NORMAL_ATTR_RESET;
         bright_attr_ff <= BRIGHT_ATTR_RESET;
      end else begin
         normal_attr_ff <= normal_attr_in;
         bright_attr_ff <= bright_attr_in;
      end
   end

   assign req_stall = q_status.full | b_status.init_busy;
   assign push      = req_valid & ~req_stall;
   assign push_data = {front_class, req_char_byte, req_read_row, req_read_column};
   assign {head_class, head_char, head_row, head_col} = head_data;

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .op          (req_op),
      .char_byte   (req_char_byte),
      .read_row    (req_read_row),
      .read_column (req_read_column),
      .item_class  (front_class)
   );

   tcw_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (b_status.pop),
      .pop_data  (head_data),
      .status    (q_status)
   );

   tcw_ram #(
      .WIDTH (16),
      .DEPTH (ROWS*COLUMNS)
   ) u_screen_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tcw_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .normal_attr       (normal_attr_ff),
      .bright_attr       (bright_attr_ff),
      .q_status          (q_status),
      .item_class        (head_class),
      .item_char         (head_char),
      .item_row          (head_row),
      .item_col          (head_col),
      .status            (b_status),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_bright_active (rsp_bright_active)
   );

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      b_status.pop |-> !q_status.empty)
      else $error("back end popped an empty queue");

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_column <= CW'(COLUMNS)))
      else $error("cursor column beyond wrap position");

   a_init_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> b_status.init_busy)
      else $error("screen clear did not start after reset");

   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      b_status.init_busy |-> !b_status.pop && !ram_rd_en)
      else $error("item taken during screen clear");

endmodule

@@ rtl/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tcw_front.sv @@
// ----------------------------------------------------------------------------
// tcw_front
// Classifies an incoming item: read range check and written byte class.
// ----------------------------------------------------------------------------
module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                       op,
   input  logic [7:0]                 char_byte,
   input  logic [$clog2(ROWS)-1:0]    read_row,
   input  logic [$clog2(COLUMNS)-1:0] read_column,
   output tcw_class_type              item_class
);

   localparam int RW = $clog2(ROWS);
   localparam int XW = $clog2(COLUMNS);

   logic [3:0] cls;

   always_comb begin
      priority if (char_byte == CH_NL) begin
         cls = CLS_NL;
      end else if (char_byte == CH_CR) begin
         cls = CLS_CR;
      end else if (char_byte == CH_TAB) begin
         cls = CLS_TAB;
      end else if (char_byte == CH_ESC) begin
         cls = CLS_ESC;
      end else if (char_byte == CH_LBRACKET) begin
         cls = CLS_LBRACKET;
      end else if (char_byte == CH_ZERO) begin
         cls = CLS_DIGIT0;
      end else if (char_byte > CH_ZERO && char_byte <= CH_NINE) begin
         cls = CLS_DIGIT_NZ;
      end else if (char_byte == CH_M) begin
         cls = CLS_M;
      end else begin
         cls = CLS_OTHER;
      end
   end

   assign item_class.is_read  = op;
   assign item_class.in_range = ({1'b0, read_row} < (RW+1)'(ROWS)) &&
                                ({1'b0, read_column} < (XW+1)'(COLUMNS));
   assign item_class.cls      = cls;

endmodule

@@ rtl/tcw_queue.sv @@
// ----------------------------------------------------------------------------
// tcw_queue
// Two-entry item queue between front end and back end.
// ----------------------------------------------------------------------------
module tcw_queue
   import tcw_pkg::*;
#(
   parameter int WIDTH = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output logic [WIDTH-1:0]     pop_data,
   output tcw_queue_status_type status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff;
   logic             wr_ptr_in;
   logic             rd_ptr_ff;
   logic             rd_ptr_in;
   logic [1:0]       count_ff;
   logic [1:0]       count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

endmodule

@@ rtl/tcw_back.sv @@
// ----------------------------------------------------------------------------
// tcw_back
// Executes items: screen store in a row ring, escape decoding, cursor,
// row clearing on newline and wrap, reset screen clear, and result register.
// ----------------------------------------------------------------------------
module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [7:0]                        normal_attr,
   input  logic [7:0]                        bright_attr,
   input  tcw_queue_status_type              q_status,
   input  tcw_class_type                     item_class,
   input  logic [7:0]                        item_char,
   input  logic [$clog2(ROWS)-1:0]           item_row,
   input  logic [$clog2(COLUMNS)-1:0]        item_col,
   output tcw_back_status_type               status,
   output logic                              ram_wr_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]   ram_wr_addr,
   output logic [15:0]                       ram_wr_data,
   output logic                              ram_rd_en,
   output logic [$clog2(ROWS*COLUMNS)-1:0]   ram_rd_addr,
   input  logic [15:0]                       ram_rd_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_cell_char,
   output logic [7:0]                        rsp_cell_attr,
   output logic [$clog2(COLUMNS+1)-1:0]      rsp_cursor_column,
   output logic                              rsp_bright_active
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS+1);
   localparam int AW    = $clog2(ROWS*COLUMNS);
   localparam int TW    = $clog2(TAB_STOP);
   localparam int CELLS = ROWS * COLUMNS;
   localparam logic [TW-1:0] TAB_SAT = TW'(COLUMNS % TAB_STOP);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_EXEC  = 3'd2;
   localparam logic [2:0] ST_CLEAR = 3'd3;
   localparam logic [2:0] ST_READ  = 3'd4;

   logic [2:0]    state_ff,    state_in;
   logic [RW-1:0] base_ff,     base_in;
   logic [RW-1:0] bottom_ff,   bottom_in;
   logic [CW-1:0] col_ff,      col_in;
   logic [TW-1:0] tabph_ff,    tabph_in;
   logic [1:0]    esc_ff,      esc_in;
   logic          nz_ff,       nz_in;
   logic          bright_ff,   bright_in;
   logic          started_ff,  started_in;
   logic [3:0]    cls_ff,      cls_in;
   logic [7:0]    char_ff,     char_in;
   logic [AW-1:0] addr_ff,     addr_in;
   logic [AW-1:0] end_ff,      end_in;
   logic          finish_ff,   finish_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic [7:0]    rsp_attr_ff, rsp_attr_in;
   logic [CW-1:0] rsp_col_ff,  rsp_col_in;
   logic          rsp_bright_ff, rsp_bright_in;

   logic          pop;
   logic          fall;
   logic          done;
   logic          do_nl;
   logic          nl_finish;
   logic [RW:0]   phys_sum;
   logic [RW-1:0] read_phys;
   logic [AW-1:0] base_addr;
   logic [AW-1:0] bottom_addr;
   logic [CW:0]   tab_next;
   logic [7:0]    cur_attr;

   always_comb begin
      phys_sum    = {1'b0, base_ff} + {1'b0, item_row};
      read_phys   = (phys_sum >= (RW+1)'(ROWS)) ? RW'(phys_sum - (RW+1)'(ROWS))
                                                : RW'(phys_sum);
      base_addr   = AW'(base_ff) * AW'(COLUMNS);
      bottom_addr = AW'(bottom_ff) * AW'(COLUMNS) + AW'(col_ff);
      tab_next    = {1'b0, col_ff} + (CW+1)'(TAB_STOP) - (CW+1)'(tabph_ff);
      cur_attr    = bright_ff ? bright_attr : normal_attr;
   end

   always_comb begin
      state_in      = state_ff;
      base_in       = base_ff;
      bottom_in     = bottom_ff;
      col_in        = col_ff;
      tabph_in      = tabph_ff;
      esc_in        = esc_ff;
      nz_in         = nz_ff;
      bright_in     = bright_ff;
      started_in    = started_ff;
      cls_in        = cls_ff;
      char_in       = char_ff;
      addr_in       = addr_ff;
      end_in        = end_ff;
      finish_in     = finish_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_char_in   = rsp_char_ff;
      rsp_attr_in   = rsp_attr_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_bright_in = rsp_bright_ff;
      pop           = 1'b0;
      fall          = 1'b0;
      done          = 1'b0;
      do_nl         = 1'b0;
      nl_finish     = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = addr_ff;
      ram_wr_data   = 16'h0000;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(read_phys) * AW'(COLUMNS) + AW'(item_col);

      unique case (state_ff)
         ST_INIT: begin
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + AW'(1);
            if (addr_ff == AW'(CELLS-1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty && (!rsp_valid_ff || !rsp_stall)) begin
               pop     = 1'b1;
               cls_in  = item_class.cls;
               char_in = item_char;
               if (item_class.is_read) begin
                  if (item_class.in_range) begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_READ;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_char_in   = 8'h00;
                     rsp_attr_in   = 8'h00;
                     rsp_col_in    = col_ff;
                     rsp_bright_in = bright_ff;
                  end
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_char_in   = ram_rd_data[7:0];
            rsp_attr_in   = ram_rd_data[15:8];
            rsp_col_in    = col_ff;
            rsp_bright_in = bright_ff;
            state_in      = ST_IDLE;
         end
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            if (addr_ff == end_ff) begin
               if (finish_ff) begin
                  done = 1'b1;
               end else begin
                  state_in = ST_EXEC;
               end
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_EXEC: begin
            if (!started_ff) begin
               started_in = 1'b1;
               esc_in     = ESC_NONE;
               do_nl      = 1'b1;
            end else begin
               unique case (esc_ff)
                  ESC_SEEN: begin
                     esc_in = ESC_NONE;
                     if (cls_ff == CLS_LBRACKET) begin
                        esc_in = ESC_CSI;
                        done   = 1'b1;
                     end else begin
                        fall = 1'b1;
                     end
                  end
                  ESC_CSI: begin
                     esc_in = ESC_NONE;
                     if (cls_ff == CLS_DIGIT0) begin
                        esc_in = ESC_CSI;
                        done   = 1'b1;
                     end else if (cls_ff == CLS_DIGIT_NZ) begin
                        esc_in = ESC_CSI;
                        nz_in  = 1'b1;
                        done   = 1'b1;
                     end else if (cls_ff == CLS_M) begin
                        bright_in = nz_ff;
                        done      = 1'b1;
                     end else begin
                        fall = 1'b1;
                     end
                  end
                  default: begin
                     esc_in = ESC_NONE;
                     fall   = 1'b1;
                  end
               endcase

               if (fall) begin
                  unique case (cls_ff)
                     CLS_NL: begin
                        do_nl     = 1'b1;
                        nl_finish = 1'b1;
                     end
                     CLS_CR: begin
                        col_in   = '0;
                        tabph_in = '0;
                        done     = 1'b1;
                     end
                     CLS_TAB: begin
                        if (tab_next > (CW+1)'(COLUMNS)) begin
                           col_in   = CW'(COLUMNS);
                           tabph_in = TAB_SAT;
                        end else begin
                           col_in   = CW'(tab_next);
                           tabph_in = '0;
                        end
                        done = 1'b1;
                     end
                     CLS_ESC: begin
                        esc_in = ESC_SEEN;
                        nz_in  = 1'b0;
                        done   = 1'b1;
                     end
                     default: begin
                        if (col_ff >= CW'(COLUMNS)) begin
                           do_nl = 1'b1;
                        end else begin
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = bottom_addr;
                           ram_wr_data = {cur_attr, char_ff};
                           col_in      = col_ff + CW'(1);
                           tabph_in    = (tabph_ff == TW'(TAB_STOP-1)) ? '0
                                                                      : tabph_ff + TW'(1);
                           done        = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (do_nl) begin
         base_in   = (base_ff == RW'(ROWS-1)) ? '0 : base_ff + RW'(1);
         bottom_in = base_ff;
         col_in    = '0;
         tabph_in  = '0;
         addr_in   = base_addr;
         end_in    = base_addr + AW'(COLUMNS-1);
         finish_in = nl_finish;
         state_in  = ST_CLEAR;
      end

      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_char_in   = 8'h00;
         rsp_attr_in   = 8'h00;
         rsp_col_in    = col_in;
         rsp_bright_in = bright_in;
         state_in      = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         base_ff      <= '0;
         bottom_ff    <= RW'(ROWS-1);
         col_ff       <= '0;
         tabph_ff     <= '0;
         esc_ff       <= ESC_NONE;
         nz_ff        <= 1'b0;
         bright_ff    <= 1'b0;
         started_ff   <= 1'b0;
         addr_ff      <= '0;
         finish_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         bottom_ff    <= bottom_in;
         col_ff       <= col_in;
         tabph_ff     <= tabph_in;
         esc_ff       <= esc_in;
         nz_ff        <= nz_in;
         bright_ff    <= bright_in;
         started_ff   <= started_in;
         addr_ff      <= addr_in;
         finish_ff    <= finish_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff        <= cls_in;
      char_ff       <= char_in;
      end_ff        <= end_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_attr_ff   <= rsp_attr_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_bright_ff <= rsp_bright_in;
   end

   assign status.init_busy  = (state_ff == ST_INIT);
   assign status.pop        = pop;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_char     = rsp_char_ff;
   assign rsp_cell_attr     = rsp_attr_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_bright_active = rsp_bright_ff;

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for text_console_writer_core. A directed table covers
// the first write, tabs, SGR escapes, newline scrolling and out-of-range
// reads. Random runs of text, tabs, escapes and cell reads follow, under
// changing attribute settings and handshake pressure. Every response is
// compared in order to its table row or an internal screen and cursor model.
// ----------------------------------------------------------------------------
module testbench
   import tcw_pkg::*;
;

   localparam int COLS          = 80;
   localparam int ROWS          = 25;
   localparam int TAB_STOP      = 8;
   localparam int PHASE_ITEMS   = 310;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 200;
   localparam int STUCK_LIMIT   = 20000;
   localparam logic OP_WRITE    = 1'b0;
   localparam logic OP_READ     = 1'b1;

   typedef struct packed {
      logic       op;
      logic [7:0] char_byte;
      logic [4:0] row;
      logic [6:0] column;
   } console_item_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [7:0] cell_attr;
      logic [6:0] cursor;
      logic       bright;
   } cell_result_type;

   typedef struct packed {
      console_item_type item;
      logic             typed;
      cell_result_type  want;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_op = OP_WRITE;
   logic [7:0] req_char_byte = '0;
   logic [4:0] req_read_row = '0;
   logic [6:0] req_read_column = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_cell_char;
   logic [7:0] rsp_cell_attr;
   logic [6:0] rsp_cursor_column;
   logic       rsp_bright_active;
   logic       csr_write = 1'b0;
   logic       csr_index = REG_NORMAL_ATTR;
   logic [7:0] csr_data = '0;

   // screen and cursor model
   logic [15:0]  screen [0:ROWS-1][0:COLS-1];
   int unsigned  cur_col;
   logic [1:0]   esc_state;
   logic         digits_nz;
   logic         bright_on;
   logic         seen_write;
   logic [7:0]   attr_normal;
   logic [7:0]   attr_bright;

   cell_result_type  expected_results [$];
   console_item_type plan_q [$];
   directed_row_type directed_tab [0:24];

   int error_count = 0;
   int idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int stuck_cycles = 0;

   text_console_writer_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_op            (req_op),
      .req_char_byte     (req_char_byte),
      .req_read_row      (req_read_row),
      .req_read_column   (req_read_column),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cell_char     (rsp_cell_char),
      .rsp_cell_attr     (rsp_cell_attr),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_bright_active (rsp_bright_active),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic console_item_type wr(input logic [7:0] b);
      console_item_type it;
      it = '0;
      it.op = OP_WRITE;
      it.char_byte = b;
      return it;
   endfunction

   function automatic console_item_type rd(input int r, input int c);
      console_item_type it;
      it = '0;
      it.op = OP_READ;
      it.row = 5'(r);
      it.column = 7'(c);
      return it;
   endfunction

   function automatic cell_result_type res(input logic [7:0] ch, input logic [7:0] at,
                                           input int col, input logic br);
      cell_result_type r;
      r.cell_char = ch;
      r.cell_attr = at;
      r.cursor = 7'(col);
      r.bright = br;
      return r;
   endfunction

   function automatic void scroll_up();
      for (int r = 0; r < ROWS - 1; r++) begin
         for (int c = 0; c < COLS; c++) screen[r][c] = screen[r+1][c];
      end
      for (int c = 0; c < COLS; c++) screen[ROWS-1][c] = '0;
      cur_col = 0;
   endfunction

   function automatic void put_char(input logic [7:0] c);
      logic absorbed;
      absorbed = 1'b0;
      case (esc_state)
         ESC_SEEN: begin
            if (c == CH_LBRACKET) begin
               esc_state = ESC_CSI;
               absorbed = 1'b1;
            end else esc_state = ESC_NONE;
         end
         ESC_CSI: begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
               if (c != CH_ZERO) digits_nz = 1'b1;
               absorbed = 1'b1;
            end else if (c == CH_M) begin
               bright_on = digits_nz;
               esc_state = ESC_NONE;
               absorbed = 1'b1;
            end else esc_state = ESC_NONE;
         end
         default: esc_state = ESC_NONE;
      endcase
      if (!absorbed) begin
         if (c == CH_NL) scroll_up();
         else if (c == CH_CR) cur_col = 0;
         else if (c == CH_TAB) begin
            cur_col = cur_col + TAB_STOP - (cur_col % TAB_STOP);
            if (cur_col > COLS) cur_col = COLS;
         end else if (c == CH_ESC) begin
            esc_state = ESC_SEEN;
            digits_nz = 1'b0;
         end else begin
            if (cur_col >= COLS) scroll_up();
            screen[ROWS-1][cur_col] = {(bright_on ? attr_bright : attr_normal), c};
            cur_col++;
         end
      end
   endfunction

   function automatic cell_result_type predict_console(input console_item_type it);
      cell_result_type r;
      r = '0;
      if (it.op == OP_WRITE) begin
         if (!seen_write) begin
            seen_write = 1'b1;
            esc_state = ESC_NONE;
            scroll_up();
         end
         put_char(it.char_byte);
      end else if (it.row < ROWS && it.column < COLS) begin
         r.cell_char = screen[it.row][it.column][7:0];
         r.cell_attr = screen[it.row][it.column][15:8];
      end
      r.cursor = 7'(cur_col);
      r.bright = bright_on;
      return r;
   endfunction

   // one random burst of items: text, tabs, newline, CR, escapes or cell reads
   function automatic void plan_chunk();
      int kind;
      int len;
      int r;
      int c;
      logic zero_only;
      logic [7:0] b;
      kind = $urandom_range(99);
      if (kind < 30) begin
         len = $urandom_range(24, 1);
         repeat (len) begin
            if ($urandom_range(9) == 0) b = 8'($urandom);
            else b = 8'($urandom_range(8'h7e, 8'h20));
            plan_q.push_back(wr(b));
         end
      end else if (kind < 38) begin
         len = $urandom_range(11, 1);
         repeat (len) plan_q.push_back(wr(CH_TAB));
      end else if (kind < 45) begin
         plan_q.push_back(wr(CH_NL));
      end else if (kind < 50) begin
         plan_q.push_back(wr(CH_CR));
      end else if (kind < 65) begin
         plan_q.push_back(wr(CH_ESC));
         plan_q.push_back(wr(CH_LBRACKET));
         len = $urandom_range(3);
         zero_only = ($urandom_range(2) == 0);
         repeat (len) begin
            plan_q.push_back(wr(zero_only ? CH_ZERO : CH_ZERO + 8'($urandom_range(9))));
         end
         plan_q.push_back(wr(CH_M));
      end else if (kind < 72) begin
         plan_q.push_back(wr(CH_ESC));
         case ($urandom_range(2))
            0: plan_q.push_back(wr(8'($urandom)));
            1: begin
               plan_q.push_back(wr(CH_LBRACKET));
               plan_q.push_back(wr(CH_ZERO + 8'($urandom_range(9))));
               plan_q.push_back(wr(8'($urandom)));
            end
            default: begin
               plan_q.push_back(wr(CH_ESC));
               plan_q.push_back(wr(CH_LBRACKET));
               plan_q.push_back(wr(CH_ZERO + 8'd1));
               plan_q.push_back(wr(CH_M));
            end
         endcase
      end else if (kind < 92) begin
         len = $urandom_range(4, 1);
         repeat (len) begin
            kind = $urandom_range(9);
            if (kind < 7) r = ROWS - 1;
            else if (kind < 9) r = $urandom_range(ROWS - 1);
            else r = $urandom_range(31);
            if ($urandom_range(9) < 6) c = (cur_col == 0) ? 0 : $urandom_range(cur_col - 1);
            else c = $urandom_range(127);
            plan_q.push_back(rd(r, c));
         end
      end else begin
         len = $urandom_range(3, 1);
         repeat (len) plan_q.push_back(wr(8'($urandom)));
      end
   endfunction

   task automatic send_item(input console_item_type it, input logic typed,
                            input cell_result_type want);
      cell_result_type r;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= it.op;
      req_char_byte <= it.char_byte;
      req_read_row <= it.row;
      req_read_column <= it.column;
      do @(posedge clock); while (req_stall);
      r = predict_console(it);
      expected_results.push_back(typed ? want : r);
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_attrs(input logic [7:0] norm, input logic [7:0] brt);
      csr_write <= 1'b1;
      csr_index <= REG_NORMAL_ATTR;
      csr_data <= norm;
      @(posedge clock);
      attr_normal = norm;
      csr_index <= REG_BRIGHT_ATTR;
      csr_data <= brt;
      @(posedge clock);
      attr_bright = brt;
      csr_write <= 1'b0;
   endtask

   // response check and receiver stall generation
   always @(posedge clock) begin
      cell_result_type got;
      cell_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = res(rsp_cell_char, rsp_cell_attr, int'(rsp_cursor_column), rsp_bright_active);
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, expected none, actual %h", $time, got);
         end else begin
            want = expected_results.pop_front();
            if (got.cell_char != want.cell_char || got.cell_attr != want.cell_attr ||
                got.cursor != want.cursor || got.bright != want.bright) begin
               error_count++;
               $display({"%0t: mismatch, expected char %h attr %h col %0d bright %b,",
                         " actual char %h attr %h col %0d bright %b"},
                        $time, want.cell_char, want.cell_attr, want.cursor, want.bright,
                        got.cell_char, got.cell_attr, got.cursor, got.bright);
            end
         end
      end
      if (hold_served != hold_asked) begin
         hold_served <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int sent;
      int chunks;
      int mode;
      logic mixed;
      for (int r = 0; r < ROWS; r++) begin
         for (int c = 0; c < COLS; c++) screen[r][c] = '0;
      end
      cur_col = 0;
      esc_state = ESC_NONE;
      digits_nz = 1'b0;
      bright_on = 1'b0;
      seen_write = 1'b0;
      attr_normal = NORMAL_ATTR_RESET;
      attr_bright = BRIGHT_ATTR_RESET;

      directed_tab[0]  = '{rd(24, 0),       1'b1, res(8'h00, 8'h00, 0, 1'b0)};
      directed_tab[1]  = '{rd(31, 127),     1'b1, res(8'h00, 8'h00, 0, 1'b0)};
      directed_tab[2]  = '{wr(8'h41),       1'b1, res(8'h00, 8'h00, 1, 1'b0)};
      directed_tab[3]  = '{rd(24, 0),       1'b1, res(8'h41, 8'h07, 1, 1'b0)};
      directed_tab[4]  = '{wr(CH_TAB),      1'b1, res(8'h00, 8'h00, 8, 1'b0)};
      directed_tab[5]  = '{wr(CH_ESC),      1'b1, res(8'h00, 8'h00, 8, 1'b0)};
      directed_tab[6]  = '{wr(CH_LBRACKET), 1'b1, res(8'h00, 8'h00, 8, 1'b0)};
      directed_tab[7]  = '{wr(CH_ZERO),     1'b1, res(8'h00, 8'h00, 8, 1'b0)};
      directed_tab[8]  = '{wr(8'h37),       1'b1, res(8'h00, 8'h00, 8, 1'b0)};
      directed_tab[9]  = '{wr(CH_M),        1'b1, res(8'h00, 8'h00, 8, 1'b1)};
      directed_tab[10] = '{wr(8'h42),       1'b1, res(8'h00, 8'h00, 9, 1'b1)};
      directed_tab[11] = '{rd(24, 8),       1'b1, res(8'h42, 8'h0f, 9, 1'b1)};
      directed_tab[12] = '{wr(CH_ESC),      1'b0, '0};
      directed_tab[13] = '{wr(CH_LBRACKET), 1'b0, '0};
      directed_tab[14] = '{wr(CH_M),        1'b0, '0};
      directed_tab[15] = '{wr(CH_ESC),      1'b0, '0};
      directed_tab[16] = '{wr(8'h78),       1'b0, '0};
      directed_tab[17] = '{wr(CH_CR),       1'b0, '0};
      directed_tab[18] = '{wr(CH_NL),       1'b0, '0};
      directed_tab[19] = '{rd(23, 0),       1'b1, res(8'h41, 8'h07, 0, 1'b0)};
      directed_tab[20] = '{wr(8'hff),       1'b1, res(8'h00, 8'h00, 1, 1'b0)};
      directed_tab[21] = '{wr(8'h00),       1'b1, res(8'h00, 8'h00, 2, 1'b0)};
      directed_tab[22] = '{rd(24, 1),       1'b1, res(8'h00, 8'h07, 2, 1'b0)};
      directed_tab[23] = '{rd(24, 79),      1'b1, res(8'h00, 8'h00, 2, 1'b0)};
      directed_tab[24] = '{rd(0, 127),      1'b1, res(8'h00, 8'h00, 2, 1'b0)};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 25; i++)
         send_item(directed_tab[i].item, directed_tab[i].typed, directed_tab[i].want);

      for (int p = 0; p < 6; p++) begin
         req_valid <= 1'b0;
         wait_drained();
         mixed = 1'b0;
         case (p)
            0: begin
               idle_pct = 0;
               stall_pct = 0;
               write_attrs(8'h00, 8'hff);
            end
            1: begin
               idle_pct = 62;
               stall_pct = 0;
               write_attrs(8'hff, 8'h00);
            end
            2: begin
               idle_pct = 0;
               stall_pct = 62;
               write_attrs(8'($urandom), 8'($urandom));
            end
            3: begin
               idle_pct = 22;
               stall_pct = 22;
               write_attrs(8'($urandom), 8'($urandom));
            end
            4: begin
               idle_pct = 0;
               stall_pct = 0;
               write_attrs(8'($urandom), 8'($urandom));
               hold_asked++;
            end
            default: begin
               mixed = 1'b1;
               write_attrs(8'($urandom), 8'($urandom));
            end
         endcase
         sent = 0;
         chunks = 0;
         while (sent < PHASE_ITEMS) begin
            if (mixed && chunks % 6 == 0) begin
               mode = $urandom_range(3);
               idle_pct = (mode == 1) ? 62 : (mode == 3) ? 22 : 0;
               stall_pct = (mode == 2) ? 62 : (mode == 3) ? 22 : 0;
            end
            plan_chunk();
            chunks++;
            while (plan_q.size() != 0) begin
               send_item(plan_q.pop_front(), 1'b0, '0);
               sent++;
            end
         end
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
